@@ hdl/dpb_pkg.sv @@
package dpb_pkg;

  // fixed field widths
  localparam int unsigned PIX_W   = 12;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned POINT_W = 32;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 64;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_INV_DEPTH_SCALE = 3'd0;
  localparam logic [CFG_AW-1:0] REG_CENTER_X        = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CENTER_Y        = 3'd2;
  localparam logic [CFG_AW-1:0] REG_INV_FOCAL_X     = 3'd3;
  localparam logic [CFG_AW-1:0] REG_INV_FOCAL_Y     = 3'd4;
  localparam logic [CFG_AW-1:0] REG_TRANSFORM_ROW_X = 3'd5;
  localparam logic [CFG_AW-1:0] REG_TRANSFORM_ROW_Y = 3'd6;
  localparam logic [CFG_AW-1:0] REG_TRANSFORM_ROW_Z = 3'd7;

  // register reset values
  localparam logic [23:0] RST_INV_DEPTH_SCALE = 24'd3355;
  localparam logic [15:0] RST_CENTER_X        = 16'd5112;
  localparam logic [15:0] RST_CENTER_Y        = 16'd3832;
  localparam logic [23:0] RST_INV_FOCAL_X     = 24'd31957;
  localparam logic [23:0] RST_INV_FOCAL_Y     = 24'd31957;
  localparam logic [63:0] RST_TRANSFORM_ROW_X = 64'd16384;
  localparam logic [63:0] RST_TRANSFORM_ROW_Y = 64'd1073741824;
  localparam logic [63:0] RST_TRANSFORM_ROW_Z = 64'd70368744177664;

  // saturation limits
  localparam logic [POINT_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [POINT_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_col;
    logic [PIX_W-1:0]   pixel_row;
    logic [DEPTH_W-1:0] depth_raw;
    logic [COLOR_W-1:0] color_first;
    logic [COLOR_W-1:0] color_second;
    logic [COLOR_W-1:0] color_third;
  } pixel_t;

  typedef struct packed {
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_y;
    logic signed [POINT_W-1:0] point_z;
    logic [COLOR_W-1:0]        out_color_first;
    logic [COLOR_W-1:0]        out_color_second;
    logic [COLOR_W-1:0]        out_color_third;
  } point_t;

endpackage

@@ hdl/dpb_xform_row.sv @@
module dpb_xform_row
  import dpb_pkg::*;
(
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [47:0]         x_i,
  input  logic [47:0]         y_i,
  input  logic [47:0]         z_i,
  input  logic [63:0]         row_i,
  output logic [POINT_W-1:0]  point_o
);

  logic signed [15:0] r0, r1, r2;
  logic signed [40:0] plo0_d, plo1_d, plo2_d, plo0_q, plo1_q, plo2_q;
  logic signed [39:0] phi0_d, phi1_d, phi2_d, phi0_q, phi1_q, phi2_q;
  logic signed [15:0] t_q;
  logic signed [41:0] shi_d, shi_q;
  logic signed [42:0] slo_d, slo_q;
  logic [63:0]        acc;
  logic               pos_ovf, neg_ovf;
  logic [POINT_W-1:0] point_d, point_q;

  assign r0 = $signed(row_i[15:0]);
  assign r1 = $signed(row_i[31:16]);
  assign r2 = $signed(row_i[47:32]);

  // stage a: 16 x 24 partial products, operands split at bit 24
  always_comb begin
    plo0_d = r0 * $signed({1'b0, x_i[23:0]});
    plo1_d = r1 * $signed({1'b0, y_i[23:0]});
    plo2_d = r2 * $signed({1'b0, z_i[23:0]});
    phi0_d = r0 * $signed(x_i[47:24]);
    phi1_d = r1 * $signed(y_i[47:24]);
    phi2_d = r2 * $signed(z_i[47:24]);
  end

  // stage b: partial sums, translation and rounding half folded into low sum
  always_comb begin
    shi_d = 42'(phi0_q) + 42'(phi1_q) + 42'(phi2_q);
    slo_d = 43'(plo0_q) + 43'(plo1_q) + 43'(plo2_q)
          + (43'(t_q) <<< 22) + 43'sd8192;
  end

  // stage c: recombine modulo 2^64, drop 14 fraction bits, saturate
  always_comb begin
    acc     = (64'(shi_q) << 24) + 64'(slo_q);
    pos_ovf = !acc[63] && (|acc[62:45]);
    neg_ovf = acc[63] && !(&acc[62:45]);
    if (pos_ovf) begin
      point_d = SAT_MAX;
    end else if (neg_ovf) begin
      point_d = SAT_MIN;
    end else begin
      point_d = acc[45:14];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo0_q  <= plo0_d;
      plo1_q  <= plo1_d;
      plo2_q  <= plo2_d;
      phi0_q  <= phi0_d;
      phi1_q  <= phi1_d;
      phi2_q  <= phi2_d;
      t_q     <= $signed(row_i[63:48]);
      shi_q   <= shi_d;
      slo_q   <= slo_d;
      point_q <= point_d;
    end
  end

  assign point_o = point_q;

endmodule

@@ hdl/depth_pixel_backprojector_unit.sv @@
// Depth pixel back-projector: one depth-image pixel per transaction in, one
// colored 3-D point per transaction out (signed Q16.16 meters, saturated).
// Z = depth * inv_depth_scale, X = (u - cx) * inv_fx * Z, Y likewise, then a
// rigid 3x4 transform is applied. Pixels with zero depth are dropped at the
// input and never reach the output. The datapath is an 8-stage pipeline that
// accepts a pixel every clock unless it is frozen. The whole pipeline
// advances together: it freezes only while a finished point sits in the
// output register and out_stall_i is high, and in_stall_o reports exactly
// that condition.
// Configuration registers (index: name) 0 inv_depth_scale, 1 center_x,
// 2 center_y, 3 inv_focal_x, 4 inv_focal_y, 5..7 transform rows x/y/z; write
// them only while no pixel is in flight. COORD_WIDTH masks u and v to that
// many low bits (capped by the 12-bit pixel fields).
module depth_pixel_backprojector_unit
  import dpb_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // pixel channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pixel_t            in_data_i,
  // point channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output point_t            out_data_o,
  // configuration write port
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i
);

  // effective coordinate bits, offset width, product widths
  localparam int unsigned CWE = (COORD_WIDTH < PIX_W) ? COORD_WIDTH : PIX_W;
  localparam int unsigned DW  = ((CWE + 4 > 16) ? CWE + 4 : 16) + 1;
  localparam int unsigned MW  = DW + 25;
  localparam int unsigned AW  = MW - 12;
  localparam int unsigned HW  = AW - 16 + 33;
  localparam int unsigned LAT = 8;

  // configuration registers
  logic [23:0] inv_depth_scale_q;
  logic [15:0] center_x_q, center_y_q;
  logic [23:0] inv_focal_x_q, inv_focal_y_q;
  logic [63:0] row_x_q, row_y_q, row_z_q;

  // pipeline control
  logic                      en;
  logic [LAT-1:0]            vld_q;
  logic [3*COLOR_W-1:0]      col_q [LAT];

  // stage 1
  logic [DW-1:0]             u_ext, v_ext, cx_ext, cy_ext;
  logic signed [DW-1:0]      dux_d, duy_d, dux_q, duy_q;
  logic [39:0]               zp_d, zp_q;
  // stage 2
  logic [40:0]               zsum;
  logic [31:0]               z16_d, z16_q;
  logic signed [MW-1:0]      mx_d, my_d, mx_q, my_q;
  // stage 3
  logic signed [MW-1:0]      mxr, myr;
  logic signed [AW-1:0]      ax_d, ay_d, ax_q, ay_q;
  logic [31:0]               z3_q;
  // stage 4
  logic [47:0]               xlo_d, ylo_d, xlo_q, ylo_q;
  logic signed [HW-1:0]      xhi_d, yhi_d, xhi_q, yhi_q;
  logic [31:0]               z4_q;
  // stage 5
  logic [48:0]               xlr, ylr;
  logic [63:0]               xs, ys;
  logic [47:0]               x48_q, y48_q;
  logic [31:0]               z5_q;
  // stages 6..8 live in the row units
  logic [POINT_W-1:0]        px, py, pz;

  // ---------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_depth_scale_q <= RST_INV_DEPTH_SCALE;
      center_x_q        <= RST_CENTER_X;
      center_y_q        <= RST_CENTER_Y;
      inv_focal_x_q     <= RST_INV_FOCAL_X;
      inv_focal_y_q     <= RST_INV_FOCAL_Y;
      row_x_q           <= RST_TRANSFORM_ROW_X;
      row_y_q           <= RST_TRANSFORM_ROW_Y;
      row_z_q           <= RST_TRANSFORM_ROW_Z;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_INV_DEPTH_SCALE: inv_depth_scale_q <= cfg_wdata_i[23:0];
        REG_CENTER_X:        center_x_q        <= cfg_wdata_i[15:0];
        REG_CENTER_Y:        center_y_q        <= cfg_wdata_i[15:0];
        REG_INV_FOCAL_X:     inv_focal_x_q     <= cfg_wdata_i[23:0];
        REG_INV_FOCAL_Y:     inv_focal_y_q     <= cfg_wdata_i[23:0];
        REG_TRANSFORM_ROW_X: row_x_q           <= cfg_wdata_i;
        REG_TRANSFORM_ROW_Y: row_y_q           <= cfg_wdata_i;
        REG_TRANSFORM_ROW_Z: row_z_q           <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // pipeline advance: everything moves unless the output is held
  // ---------------------------------------------------------------------
  assign en         = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o = !en;

  // valid bits; zero-depth pixels are dropped right at the entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i && (in_data_i.depth_raw != '0)};
    end
  end

  // colors ride along untouched
  always_ff @(posedge clk_i) begin
    if (en) begin
      col_q[0] <= {in_data_i.color_first, in_data_i.color_second,
                   in_data_i.color_third};
      for (int i = 1; i < LAT; i++) begin
        col_q[i] <= col_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: depth product, pixel offsets from the principal point (Q.4)
  // ---------------------------------------------------------------------
  always_comb begin
    u_ext  = DW'(in_data_i.pixel_col[CWE-1:0]);
    v_ext  = DW'(in_data_i.pixel_row[CWE-1:0]);
    cx_ext = DW'(center_x_q);
    cy_ext = DW'(center_y_q);
    dux_d  = $signed(u_ext << 4) - $signed(cx_ext);
    duy_d  = $signed(v_ext << 4) - $signed(cy_ext);
    zp_d   = in_data_i.depth_raw * inv_depth_scale_q;
  end

  // ---------------------------------------------------------------------
  // stage 2: round z to Q16.16, offset times reciprocal focal length
  // ---------------------------------------------------------------------
  always_comb begin
    zsum  = {1'b0, zp_q} + 41'd128;
    z16_d = zsum[39:8];
    mx_d  = dux_q * $signed({1'b0, inv_focal_x_q});
    my_d  = duy_q * $signed({1'b0, inv_focal_y_q});
  end

  // ---------------------------------------------------------------------
  // stage 3: round normalized offsets to Q.16
  // ---------------------------------------------------------------------
  always_comb begin
    mxr  = mx_q + $signed(MW'(2048));
    myr  = my_q + $signed(MW'(2048));
    ax_d = mxr[MW-1:12];
    ay_d = myr[MW-1:12];
  end

  // ---------------------------------------------------------------------
  // stage 4: offset times z, split into low and high partial products
  // ---------------------------------------------------------------------
  always_comb begin
    xlo_d = ax_q[15:0] * z3_q;
    ylo_d = ay_q[15:0] * z3_q;
    xhi_d = $signed(ax_q[AW-1:16]) * $signed({1'b0, z3_q});
    yhi_d = $signed(ay_q[AW-1:16]) * $signed({1'b0, z3_q});
  end

  // ---------------------------------------------------------------------
  // stage 5: recombine, round away 16 bits, keep 48 bits (wraps mod 2^64)
  // ---------------------------------------------------------------------
  always_comb begin
    xlr = {1'b0, xlo_q} + 49'd32768;
    ylr = {1'b0, ylo_q} + 49'd32768;
    xs  = 64'(xhi_q) + 64'(xlr[48:16]);
    ys  = 64'(yhi_q) + 64'(ylr[48:16]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dux_q <= dux_d;
      duy_q <= duy_d;
      zp_q  <= zp_d;
      z16_q <= z16_d;
      mx_q  <= mx_d;
      my_q  <= my_d;
      ax_q  <= ax_d;
      ay_q  <= ay_d;
      z3_q  <= z16_q;
      xlo_q <= xlo_d;
      ylo_q <= ylo_d;
      xhi_q <= xhi_d;
      yhi_q <= yhi_d;
      z4_q  <= z3_q;
      x48_q <= xs[47:0];
      y48_q <= ys[47:0];
      z5_q  <= z4_q;
    end
  end

  // ---------------------------------------------------------------------
  // stages 6..8: one transform row per output coordinate
  // ---------------------------------------------------------------------
  dpb_xform_row u_row_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (x48_q),
    .y_i     (y48_q),
    .z_i     ({16'd0, z5_q}),
    .row_i   (row_x_q),
    .point_o (px)
  );

  dpb_xform_row u_row_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (x48_q),
    .y_i     (y48_q),
    .z_i     ({16'd0, z5_q}),
    .row_i   (row_y_q),
    .point_o (py)
  );

  dpb_xform_row u_row_z (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (x48_q),
    .y_i     (y48_q),
    .z_i     ({16'd0, z5_q}),
    .row_i   (row_z_q),
    .point_o (pz)
  );

  // output register is the last row stage plus the color shift line
  assign out_valid_o                 = vld_q[LAT-1];
  assign out_data_o.point_x          = $signed(px);
  assign out_data_o.point_y          = $signed(py);
  assign out_data_o.point_z          = $signed(pz);
  assign out_data_o.out_color_first  = col_q[LAT-1][3*COLOR_W-1:2*COLOR_W];
  assign out_data_o.out_color_second = col_q[LAT-1][2*COLOR_W-1:COLOR_W];
  assign out_data_o.out_color_third  = col_q[LAT-1][COLOR_W-1:0];

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // input backpressure only comes from a held output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output");

  // a zero-depth pixel never enters the pipeline
  a_zero_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_data_i.depth_raw == '0)) |=> !vld_q[0])
    else $error("zero-depth pixel entered the pipeline");

  // a frozen pipeline keeps all its valid bits
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q))
    else $error("valid bits moved during a stall");

  // an accepted nonzero pixel is in stage one on the next cycle
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_data_i.depth_raw != '0)) |=> vld_q[0])
    else $error("accepted pixel lost at entry");

endmodule

@@ tb/point_cloud_checker.sv @@
module point_cloud_checker
  import dpb_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  pixel_t            in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  point_t            out_data_i,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  output int                errors_o,
  output int                pending_o,
  output int                points_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the register file
  logic [23:0] depth_scale;
  logic [15:0] cen_x;
  logic [15:0] cen_y;
  logic [23:0] foc_x;
  logic [23:0] foc_y;
  logic [63:0] row_x;
  logic [63:0] row_y;
  logic [63:0] row_z;

  point_t predicted_points[$];
  int     mismatches;
  int     compared;

  // add half, then floor
  function automatic longint round_half_up(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint lateral_offset(logic [PIX_W-1:0] coord, logic [15:0] center,
                                            logic [23:0] inv_focal, longint z16);
    longint cu;
    longint cc;
    longint fi;
    longint a;
    cu = coord;
    cu = cu & ((longint'(1) <<< COORD_WIDTH) - 1);
    cc = center;
    fi = inv_focal;
    a  = round_half_up((cu * 16 - cc) * fi, 12);
    return round_half_up(a * z16, 16);
  endfunction

  function automatic logic [POINT_W-1:0] apply_row(logic [63:0] row, longint x, longint y,
                                                   longint z);
    longint acc;
    longint r;
    acc = longint'($signed(row[15:0])) * x + longint'($signed(row[31:16])) * y
        + longint'($signed(row[47:32])) * z + (longint'($signed(row[63:48])) <<< 22);
    r = round_half_up(acc, 14);
    if (r > longint'($signed(SAT_MAX))) return SAT_MAX;
    if (r < longint'($signed(SAT_MIN))) return SAT_MIN;
    return r[POINT_W-1:0];
  endfunction

  function automatic point_t project_pixel(pixel_t px);
    point_t pt;
    longint d;
    longint s;
    longint z16;
    longint x16;
    longint y16;
    d   = px.depth_raw;
    s   = depth_scale;
    z16 = (d * s + 128) >>> 8;
    x16 = lateral_offset(px.pixel_col, cen_x, foc_x, z16);
    y16 = lateral_offset(px.pixel_row, cen_y, foc_y, z16);
    pt.point_x          = apply_row(row_x, x16, y16, z16);
    pt.point_y          = apply_row(row_y, x16, y16, z16);
    pt.point_z          = apply_row(row_z, x16, y16, z16);
    pt.out_color_first  = px.color_first;
    pt.out_color_second = px.color_second;
    pt.out_color_third  = px.color_third;
    return pt;
  endfunction

  task automatic compare_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    point_t want;
    if (!rst_ni) begin
      depth_scale = RST_INV_DEPTH_SCALE;
      cen_x       = RST_CENTER_X;
      cen_y       = RST_CENTER_Y;
      foc_x       = RST_INV_FOCAL_X;
      foc_y       = RST_INV_FOCAL_Y;
      row_x       = RST_TRANSFORM_ROW_X;
      row_y       = RST_TRANSFORM_ROW_Y;
      row_z       = RST_TRANSFORM_ROW_Z;
      predicted_points.delete();
      mismatches  = 0;
      compared    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_INV_DEPTH_SCALE: depth_scale = cfg_wdata_i[23:0];
          REG_CENTER_X:        cen_x       = cfg_wdata_i[15:0];
          REG_CENTER_Y:        cen_y       = cfg_wdata_i[15:0];
          REG_INV_FOCAL_X:     foc_x       = cfg_wdata_i[23:0];
          REG_INV_FOCAL_Y:     foc_y       = cfg_wdata_i[23:0];
          REG_TRANSFORM_ROW_X: row_x       = cfg_wdata_i;
          REG_TRANSFORM_ROW_Y: row_y       = cfg_wdata_i;
          REG_TRANSFORM_ROW_Z: row_z       = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (predicted_points.size() == 0) begin
          $error("point transaction with no pixel outstanding");
          mismatches++;
        end else begin
          want = predicted_points.pop_front();
          compare_field("point_x", want.point_x, out_data_i.point_x);
          compare_field("point_y", want.point_y, out_data_i.point_y);
          compare_field("point_z", want.point_z, out_data_i.point_z);
          compare_field("out_color_first", want.out_color_first, out_data_i.out_color_first);
          compare_field("out_color_second", want.out_color_second,
                        out_data_i.out_color_second);
          compare_field("out_color_third", want.out_color_third, out_data_i.out_color_third);
          compared++;
        end
      end
      // zero depth gives no point
      if (in_valid_i && !in_stall_i && in_data_i.depth_raw != '0) begin
        predicted_points.insert(predicted_points.size(), project_pixel(in_data_i));
      end
    end
    errors_o  <= mismatches;
    pending_o <= predicted_points.size();
    points_o  <= compared;
  end

endmodule

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dpb_pkg::*;

  localparam int unsigned COORD_WIDTH = 12;
  localparam int HALF_PERIOD     = 5;
  localparam int RESET_CYCLES    = 10;
  localparam int PIPE_LATENCY    = 8;
  localparam int STALL_LIMIT     = 2000;
  localparam int NUM_REGS        = 8;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int IDLE_PERCENT    = 11;

  // kinds of register settings for the random phases
  typedef enum int {
    SET_DEFAULT,
    SET_ZERO,
    SET_REALISTIC,
    SET_RANDOM
  } setting_e;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  pixel_t            in_data     = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  point_t            out_data;
  logic              cfg_we      = 1'b0;
  logic [CFG_AW-1:0] cfg_addr    = '0;
  logic [CFG_DW-1:0] cfg_wdata   = '0;

  int check_errors;
  int pending_points;
  int points_checked;

  // random idling of both sides, switched off for a quiet stretch
  logic idling_on = 1'b1;

  logic [CFG_DW-1:0] cfg_set [NUM_REGS];
  setting_e          schedule [NUM_PHASES] = '{SET_DEFAULT, SET_ZERO, SET_REALISTIC,
                                               SET_RANDOM, SET_RANDOM, SET_REALISTIC};
  int pixels_sent     = 0;
  int empty_pixels    = 0;
  int settings_loaded = 0;
  int quiet_cycles    = 0;

  always #HALF_PERIOD clk_i = ~clk_i;

  depth_pixel_backprojector_unit #(
    .COORD_WIDTH(COORD_WIDTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_addr_i (cfg_addr),
    .cfg_wdata_i(cfg_wdata)
  );

  // watches both channels and the register port, predicts and compares
  point_cloud_checker #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_addr_i (cfg_addr),
    .cfg_wdata_i(cfg_wdata),
    .errors_o   (check_errors),
    .pending_o  (pending_points),
    .points_o   (points_checked)
  );

  // point receiver stalls at random
  always @(posedge clk_i) begin
    out_stall <= idling_on && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  // watchdog: too long without any transaction ends the run
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[depth_pixel_backprojector_unit] ERROR");
      $finish;
    end
  end

  function automatic pixel_t pix(int u, int v, int d, int c1, int c2, int c3);
    pixel_t p;
    p.pixel_col    = PIX_W'(u);
    p.pixel_row    = PIX_W'(v);
    p.depth_raw    = DEPTH_W'(d);
    p.color_first  = COLOR_W'(c1);
    p.color_second = COLOR_W'(c2);
    p.color_third  = COLOR_W'(c3);
    return p;
  endfunction

  // mostly full-range content, with image borders and depth extremes mixed in
  function automatic pixel_t random_pixel();
    pixel_t p;
    int     pick;
    p = pix($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    pick = $urandom_range(0, 99);
    if (pick < 4) p.pixel_col = '0;
    else if (pick < 8) p.pixel_col = '1;
    pick = $urandom_range(0, 99);
    if (pick < 4) p.pixel_row = '0;
    else if (pick < 8) p.pixel_row = '1;
    pick = $urandom_range(0, 99);
    if (pick < 12) p.depth_raw = '0;
    else if (pick < 15) p.depth_raw = DEPTH_W'(1);
    else if (pick < 18) p.depth_raw = '1;
    else if (pick < 40) p.depth_raw = DEPTH_W'($urandom_range(300, 12000));
    return p;
  endfunction

  // near-identity rotation row with a random translation
  function automatic logic [63:0] near_identity_row(int diag);
    logic [15:0] term [3];
    for (int k = 0; k < 3; k++) begin
      term[k] = 16'(int'($urandom_range(0, 4095)) - 2048);
      if (k == diag) term[k] = term[k] + 16'h4000;
    end
    return {16'($urandom()), term[2], term[1], term[0]};
  endfunction

  task automatic choose_settings(setting_e kind);
    case (kind)
      SET_DEFAULT: begin
        cfg_set[REG_INV_DEPTH_SCALE] = CFG_DW'(RST_INV_DEPTH_SCALE);
        cfg_set[REG_CENTER_X]        = CFG_DW'(RST_CENTER_X);
        cfg_set[REG_CENTER_Y]        = CFG_DW'(RST_CENTER_Y);
        cfg_set[REG_INV_FOCAL_X]     = CFG_DW'(RST_INV_FOCAL_X);
        cfg_set[REG_INV_FOCAL_Y]     = CFG_DW'(RST_INV_FOCAL_Y);
        cfg_set[REG_TRANSFORM_ROW_X] = RST_TRANSFORM_ROW_X;
        cfg_set[REG_TRANSFORM_ROW_Y] = RST_TRANSFORM_ROW_Y;
        cfg_set[REG_TRANSFORM_ROW_Z] = RST_TRANSFORM_ROW_Z;
      end
      SET_ZERO: begin
        for (int i = 0; i < NUM_REGS; i++) cfg_set[i] = '0;
      end
      SET_REALISTIC: begin
        cfg_set[REG_INV_DEPTH_SCALE] = CFG_DW'($urandom_range(1000, 20000));
        cfg_set[REG_CENTER_X]        = CFG_DW'($urandom_range(0, 65535));
        cfg_set[REG_CENTER_Y]        = CFG_DW'($urandom_range(0, 65535));
        cfg_set[REG_INV_FOCAL_X]     = CFG_DW'($urandom_range(8000, 80000));
        cfg_set[REG_INV_FOCAL_Y]     = CFG_DW'($urandom_range(8000, 80000));
        cfg_set[REG_TRANSFORM_ROW_X] = near_identity_row(0);
        cfg_set[REG_TRANSFORM_ROW_Y] = near_identity_row(1);
        cfg_set[REG_TRANSFORM_ROW_Z] = near_identity_row(2);
      end
      default: begin
        // full-width random values, upper bits beyond a register's width included
        for (int i = 0; i < NUM_REGS; i++) cfg_set[i] = {$urandom(), $urandom()};
      end
    endcase
  endtask

  // writes the whole register file, one register per clock
  task automatic load_registers();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_AW'(i);
      cfg_wdata <= cfg_set[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // one pixel transaction, preceded by random idle cycles
  task automatic push_pixel(pixel_t px);
    while (idling_on && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    pixels_sent++;
    if (px.depth_raw == '0) empty_pixels++;
  endtask

  // wait for every predicted point, then let dropped pixels leave the pipeline
  task automatic settle_pipeline();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_points != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pixels under the reset settings: field extremes, zero depth,
    // principal point and image corners
    push_pixel(pix(0, 0, 1, 0, 0, 0));
    push_pixel(pix(4095, 4095, 65535, 255, 255, 255));
    push_pixel(pix(0, 0, 0, 255, 255, 255));
    push_pixel(pix(4095, 0, 65535, 170, 85, 15));
    push_pixel(pix(0, 4095, 65535, 85, 170, 240));
    push_pixel(pix(320, 240, 5000, 1, 2, 3));
    push_pixel(pix(319, 239, 0, 9, 8, 7));
    push_pixel(pix(2048, 1024, 32768, 128, 64, 32));
    push_pixel(pix(1, 1, 1, 254, 1, 127));
    push_pixel(pix(4095, 4095, 1, 0, 255, 0));
    settle_pipeline();

    // extreme settings drive all three coordinates into saturation, both signs
    cfg_set[REG_INV_DEPTH_SCALE] = CFG_DW'(24'hff_ffff);
    cfg_set[REG_CENTER_X]        = CFG_DW'(16'hffff);
    cfg_set[REG_CENTER_Y]        = '0;
    cfg_set[REG_INV_FOCAL_X]     = CFG_DW'(24'hff_ffff);
    cfg_set[REG_INV_FOCAL_Y]     = CFG_DW'(24'hff_ffff);
    cfg_set[REG_TRANSFORM_ROW_X] = {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
    cfg_set[REG_TRANSFORM_ROW_Y] = {16'h8000, 16'h8000, 16'h8000, 16'h8000};
    cfg_set[REG_TRANSFORM_ROW_Z] = {16'h8000, 16'h7fff, 16'h0000, 16'h8000};
    load_registers();
    push_pixel(pix(0, 0, 65535, 0, 0, 0));
    push_pixel(pix(4095, 4095, 65535, 255, 255, 255));
    push_pixel(pix(0, 0, 1, 51, 102, 153));
    push_pixel(pix(4095, 0, 65535, 204, 17, 68));
    push_pixel(pix(0, 4095, 0, 1, 1, 1));
    push_pixel(pix(2048, 2048, 40000, 99, 199, 249));
    push_pixel(pix(4095, 2048, 2, 7, 77, 177));
    push_pixel(pix(1, 4095, 12345, 3, 33, 233));
    settle_pipeline();

    // random phases, each with its own register settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      choose_settings(schedule[ph]);
      load_registers();
      // the first realistic phase runs with no idling on either side
      idling_on <= (ph != 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) push_pixel(random_pixel());
      settle_pipeline();
    end

    $display("summary: %0d pixels sent (%0d with zero depth), %0d points compared",
             pixels_sent, empty_pixels, points_checked);
    $display("summary: %0d register settings loaded, saturation and zero transforms included",
             settings_loaded);
    if (check_errors == 0 && pending_points == 0) begin
      $display("[depth_pixel_backprojector_unit] OK");
    end else begin
      $display("[depth_pixel_backprojector_unit] ERROR");
    end
    $finish;
  end

endmodule
